// ===== rtl/ttb_pkg.sv =====
// Shared types and constants of the triangle tangent basis block.
`timescale 1ns / 1ps

package ttb_pkg;

    localparam int COORD_W = 32;
    localparam int DELTA_W = COORD_W + 1;
    localparam int PROD_W  = 2 * DELTA_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int NORM_W  = 30;
    localparam int SUM_W   = 2 * NORM_W + 2;
    localparam int LEN_W   = NORM_W + 1;
    localparam int QFRAC   = 15;
    localparam int NUM_W   = NORM_W + QFRAC + 1;
    localparam int QUOT_W  = QFRAC + 1;
    localparam int OUT_W   = 16;
    localparam int NUM_PRODUCTS = 14;
    localparam int QSAT    = 32767;

    typedef struct packed {
        logic                       first_vertex;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [COORD_W-1:0]  pos_z;
        logic signed [COORD_W-1:0]  tex_u;
        logic signed [COORD_W-1:0]  tex_v;
    } t_vertex;

    typedef struct packed {
        logic signed [OUT_W-1:0] tangent_x;
        logic signed [OUT_W-1:0] tangent_y;
        logic signed [OUT_W-1:0] tangent_z;
        logic signed [OUT_W-1:0] bitangent_x;
        logic signed [OUT_W-1:0] bitangent_y;
        logic signed [OUT_W-1:0] bitangent_z;
        logic                    degenerate;
    } t_result;

    typedef struct packed {
        logic signed [DELTA_W-1:0] e1_x;
        logic signed [DELTA_W-1:0] e1_y;
        logic signed [DELTA_W-1:0] e1_z;
        logic signed [DELTA_W-1:0] e2_x;
        logic signed [DELTA_W-1:0] e2_y;
        logic signed [DELTA_W-1:0] e2_z;
        logic signed [DELTA_W-1:0] d1_u;
        logic signed [DELTA_W-1:0] d1_v;
        logic signed [DELTA_W-1:0] d2_u;
        logic signed [DELTA_W-1:0] d2_v;
    } t_deltas;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_CHECK,
        ST_LOAD,
        ST_SHIFT,
        ST_SQUARE,
        ST_ROOT,
        ST_DIV,
        ST_FINISH
    } t_state;

endpackage

// ===== rtl/ttb_vstore.sv =====
// Vertex holding registers and edge / UV delta formation.
`timescale 1ns / 1ps

module ttb_vstore (
    input  logic             i_clk,
    input  logic             i_hold_en,
    input  logic             i_slot,
    input  logic             i_last_en,
    input  ttb_pkg::t_vertex i_vertex,
    output ttb_pkg::t_deltas o_deltas
);

    logic signed [ttb_pkg::COORD_W-1:0] r_px [2];
    logic signed [ttb_pkg::COORD_W-1:0] r_py [2];
    logic signed [ttb_pkg::COORD_W-1:0] r_pz [2];
    logic signed [ttb_pkg::COORD_W-1:0] r_tu [2];
    logic signed [ttb_pkg::COORD_W-1:0] r_tv [2];
    ttb_pkg::t_vertex                   r_v2;

    always_ff @(posedge i_clk) begin
        if (i_hold_en) begin
            r_px[i_slot] <= i_vertex.pos_x;
            r_py[i_slot] <= i_vertex.pos_y;
            r_pz[i_slot] <= i_vertex.pos_z;
            r_tu[i_slot] <= i_vertex.tex_u;
            r_tv[i_slot] <= i_vertex.tex_v;
        end
        if (i_last_en) begin
            r_v2 <= i_vertex;
        end
    end

    // Exact 33-bit differences against vertex 0.
    always_comb begin
        o_deltas.e1_x = ttb_pkg::DELTA_W'(r_px[1]) - ttb_pkg::DELTA_W'(r_px[0]);
        o_deltas.e1_y = ttb_pkg::DELTA_W'(r_py[1]) - ttb_pkg::DELTA_W'(r_py[0]);
        o_deltas.e1_z = ttb_pkg::DELTA_W'(r_pz[1]) - ttb_pkg::DELTA_W'(r_pz[0]);
        o_deltas.e2_x = ttb_pkg::DELTA_W'(r_v2.pos_x) - ttb_pkg::DELTA_W'(r_px[0]);
        o_deltas.e2_y = ttb_pkg::DELTA_W'(r_v2.pos_y) - ttb_pkg::DELTA_W'(r_py[0]);
        o_deltas.e2_z = ttb_pkg::DELTA_W'(r_v2.pos_z) - ttb_pkg::DELTA_W'(r_pz[0]);
        o_deltas.d1_u = ttb_pkg::DELTA_W'(r_tu[1]) - ttb_pkg::DELTA_W'(r_tu[0]);
        o_deltas.d1_v = ttb_pkg::DELTA_W'(r_tv[1]) - ttb_pkg::DELTA_W'(r_tv[0]);
        o_deltas.d2_u = ttb_pkg::DELTA_W'(r_v2.tex_u) - ttb_pkg::DELTA_W'(r_tu[0]);
        o_deltas.d2_v = ttb_pkg::DELTA_W'(r_v2.tex_v) - ttb_pkg::DELTA_W'(r_tv[0]);
    end

endmodule

// ===== rtl/ttb_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module ttb_mul (
    input  logic                                i_clk,
    input  logic signed [ttb_pkg::DELTA_W-1:0]  i_a,
    input  logic signed [ttb_pkg::DELTA_W-1:0]  i_b,
    output logic signed [ttb_pkg::PROD_W-1:0]   o_prod
);

    logic signed [ttb_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/ttb_root.sv =====
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module ttb_root (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ttb_pkg::SUM_W-1:0]    i_value,
    output logic                         o_done,
    output logic [ttb_pkg::LEN_W-1:0]    o_root
);

    logic                          r_busy;
    logic                          r_done;
    logic [ttb_pkg::SUM_W-1:0]     r_v;
    logic [ttb_pkg::SUM_W-1:0]     r_res;
    logic [ttb_pkg::SUM_W-1:0]     r_bit;
    logic [ttb_pkg::SUM_W:0]       trial;

    assign trial = {1'b0, r_res} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_res <= '0;
            r_bit <= {2'b01, {(ttb_pkg::SUM_W-2){1'b0}}};
        end else if (r_busy) begin
            if ({1'b0, r_v} >= trial) begin
                r_v   <= r_v - trial[ttb_pkg::SUM_W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ttb_pkg::LEN_W-1:0];

endmodule

// ===== rtl/ttb_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ttb_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ttb_pkg::NUM_W-1:0]     i_num,
    input  logic [ttb_pkg::LEN_W-1:0]     i_den,
    output logic                          o_done,
    output logic [ttb_pkg::QUOT_W-1:0]    o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [3:0]                    r_cnt;
    logic [ttb_pkg::NUM_W-1:0]     r_rem;
    logic [ttb_pkg::NUM_W-1:0]     r_d;
    logic [ttb_pkg::QUOT_W-1:0]    r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 4'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_d   <= {i_den, {ttb_pkg::QFRAC{1'b0}}};
            r_q   <= '0;
            r_cnt <= 4'(ttb_pkg::QUOT_W - 1);
        end else if (r_busy) begin
            if (r_rem >= r_d) begin
                r_rem <= r_rem - r_d;
                r_q   <= {r_q[ttb_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[ttb_pkg::QUOT_W-2:0], 1'b0};
            end
            r_d   <= r_d >> 1;
            r_cnt <= r_cnt - 4'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/triangle_tangent_basis.sv =====
// Top level of the per-triangle tangent and bitangent unit.
// Usage: vertices arrive as requests on the input channel (i_valid / o_ready,
// payload i_vertex). The first two vertices of each triangle are held in
// registers while idle. A set first_vertex bit restarts triangle grouping, so
// a partial triangle is dropped without a result. The third vertex starts
// the computation and yields one result request on the output channel
// (o_valid / i_ready, payload o_result).
// Processing of the third vertex: one shared multiplier forms the UV
// determinant and both cross terms; each of the two vectors then goes
// through normalization shifts, squaring, the iterative root and three
// divisions. A zero determinant, or a zero vector, ends the work early with
// a degenerate result. o_ready stays low until the result is loaded.
// The finished result sits in an output register, so new vertices are taken
// while the receiver stalls; a second result waits until that register empties.
// Reset (synchronous, active low) clears the triangle phase and the sequencer;
// the held vertices are not cleared, as no result can use them before written.
`timescale 1ns / 1ps

module triangle_tangent_basis (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ttb_pkg::t_vertex i_vertex,
    output logic             o_valid,
    input  logic             i_ready,
    output ttb_pkg::t_result o_result
);

    ttb_pkg::t_state r_state, n_state;
    logic [1:0]      r_phase, n_phase;
    logic [1:0]      eff_phase;
    logic            accept;
    logic            hold_en;
    logic            last_en;

    ttb_pkg::t_deltas deltas;
    logic signed [ttb_pkg::DELTA_W-1:0] e1 [3];
    logic signed [ttb_pkg::DELTA_W-1:0] e2 [3];

    logic signed [ttb_pkg::DELTA_W-1:0] mul_a, mul_b;
    logic signed [ttb_pkg::PROD_W-1:0]  prod;
    logic signed [ttb_pkg::ACC_W-1:0]   prod_ext;
    logic [3:0]                         r_cnt;
    logic [3:0]                         prod_idx;
    logic [3:0]                         op_idx;
    logic [1:0]                         op_k;

    logic signed [ttb_pkg::ACC_W-1:0]   r_acc;
    logic signed [ttb_pkg::ACC_W-1:0]   r_res [7];

    logic                               r_vec;
    logic                               r_degen;
    logic [ttb_pkg::MAG_W-1:0]          r_m [3];
    logic [2:0]                         r_neg;
    logic [ttb_pkg::ACC_W-1:0]          ld_src [3];
    logic [ttb_pkg::ACC_W-1:0]          ld_negv [3];
    logic [ttb_pkg::MAG_W-1:0]          ld_mag [3];
    logic                               ld_zero;
    logic [ttb_pkg::MAG_W-1:0]          m_or;
    logic                               norm_hi;

    logic [ttb_pkg::SUM_W-1:0]          r_sum;
    logic [ttb_pkg::SUM_W-1:0]          sq_total;
    logic [ttb_pkg::LEN_W-1:0]          r_len;
    logic [1:0]                         r_comp;
    logic [1:0]                         div_comp;
    logic [1:0]                         m_sel;
    logic [ttb_pkg::MAG_W-1:0]          m_rd;

    logic                               root_start, root_done;
    logic [ttb_pkg::LEN_W-1:0]          root_val;
    logic                               div_start, div_done;
    logic [ttb_pkg::LEN_W-1:0]          div_den;
    logic [ttb_pkg::NUM_W-1:0]          div_num;
    logic [ttb_pkg::QUOT_W-1:0]         div_quot;
    logic [ttb_pkg::QFRAC-1:0]          q_mag;
    logic signed [ttb_pkg::OUT_W-1:0]   q_signed;

    logic signed [ttb_pkg::OUT_W-1:0]   r_tq [3];
    logic signed [ttb_pkg::OUT_W-1:0]   r_bq [3];
    ttb_pkg::t_result                   r_out;
    logic                               r_out_valid;
    logic                               out_load;

    // A first-vertex mark, or the unused phase code, starts a new triangle.
    assign eff_phase = (i_vertex.first_vertex || r_phase == 2'd3) ? 2'd0 : r_phase;
    assign accept    = i_valid && o_ready;

    ttb_vstore u_vstore (
        .i_clk     (i_clk),
        .i_hold_en (hold_en),
        .i_slot    (eff_phase[0]),
        .i_last_en (last_en),
        .i_vertex  (i_vertex),
        .o_deltas  (deltas)
    );

    assign e1[0] = deltas.e1_x;
    assign e1[1] = deltas.e1_y;
    assign e1[2] = deltas.e1_z;
    assign e2[0] = deltas.e2_x;
    assign e2[1] = deltas.e2_y;
    assign e2[2] = deltas.e2_z;

    // Operand schedule of the shared multiplier. In the product phase the
    // determinant pair comes first, then for each axis the two tangent terms
    // and the two bitangent terms. In the square phase it squares the
    // normalized magnitudes one after another.
    assign op_idx = r_cnt - 4'd2;
    assign op_k   = op_idx[3:2];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ttb_pkg::ST_PROD) begin
            if (r_cnt == 4'd0) begin
                mul_a = deltas.d1_u;
                mul_b = deltas.d2_v;
            end else if (r_cnt == 4'd1) begin
                mul_a = deltas.d2_u;
                mul_b = deltas.d1_v;
            end else if (r_cnt < 4'(ttb_pkg::NUM_PRODUCTS)) begin
                case (op_idx[1:0])
                    2'd0: begin
                        mul_a = deltas.d2_v;
                        mul_b = e1[op_k];
                    end
                    2'd1: begin
                        mul_a = deltas.d1_v;
                        mul_b = e2[op_k];
                    end
                    2'd2: begin
                        mul_a = deltas.d1_u;
                        mul_b = e2[op_k];
                    end
                    default: begin
                        mul_a = deltas.d2_u;
                        mul_b = e1[op_k];
                    end
                endcase
            end
        end else if (r_state == ttb_pkg::ST_SQUARE) begin
            mul_a = {3'b000, m_rd[ttb_pkg::NORM_W-1:0]};
            mul_b = {3'b000, m_rd[ttb_pkg::NORM_W-1:0]};
        end
    end

    ttb_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign prod_ext = {prod[ttb_pkg::PROD_W-1], prod};
    assign prod_idx = r_cnt - 4'd1;

    // Magnitudes of the vector being normalized; tangent terms sit in the odd
    // result slots and bitangent terms in the even ones after the determinant.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ld_src[k]  = r_vec ? r_res[2 + 2 * k] : r_res[1 + 2 * k];
            ld_negv[k] = -ld_src[k];
            ld_mag[k]  = ld_src[k][ttb_pkg::ACC_W-1] ? ld_negv[k][ttb_pkg::MAG_W-1:0]
                                                      : ld_src[k][ttb_pkg::MAG_W-1:0];
        end
    end

    assign ld_zero = (ld_mag[0] | ld_mag[1] | ld_mag[2]) == '0;
    assign m_or    = r_m[0] | r_m[1] | r_m[2];
    assign norm_hi = |m_or[ttb_pkg::MAG_W-1:ttb_pkg::NORM_W];

    assign sq_total = r_sum + prod[ttb_pkg::SUM_W-1:0];

    // One read port on the working magnitudes, shared by squaring and division.
    assign div_comp = (r_state == ttb_pkg::ST_ROOT) ? 2'd0 : r_comp + 2'd1;
    assign m_sel    = (r_state == ttb_pkg::ST_SQUARE) ? r_cnt[1:0] : div_comp;
    assign m_rd     = (m_sel == 2'd3) ? '0 : r_m[m_sel];
    assign div_den  = (r_state == ttb_pkg::ST_ROOT) ? root_val : r_len;
    assign div_num  = {1'b0, m_rd[ttb_pkg::NORM_W-1:0], {ttb_pkg::QFRAC{1'b0}}}
                    + {{(ttb_pkg::NUM_W-ttb_pkg::LEN_W+1){1'b0}},
                       div_den[ttb_pkg::LEN_W-1:1]};

    ttb_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_value (sq_total),
        .o_done  (root_done),
        .o_root  (root_val)
    );

    ttb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Saturate to the largest Q1.15 value and restore the sign.
    assign q_mag    = div_quot[ttb_pkg::QUOT_W-1] ? ttb_pkg::QFRAC'(ttb_pkg::QSAT)
                                                  : div_quot[ttb_pkg::QFRAC-1:0];
    assign q_signed = r_neg[r_comp] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

    // Sequencer next state and handshake.
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        o_ready    = 1'b0;
        hold_en    = 1'b0;
        last_en    = 1'b0;
        root_start = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ttb_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (accept) begin
                    if (eff_phase == 2'd2) begin
                        last_en = 1'b1;
                        n_phase = 2'd0;
                        n_state = ttb_pkg::ST_PROD;
                    end else begin
                        hold_en = 1'b1;
                        n_phase = eff_phase + 2'd1;
                    end
                end
            end
            ttb_pkg::ST_PROD: begin
                if (r_cnt == 4'(ttb_pkg::NUM_PRODUCTS)) begin
                    n_state = ttb_pkg::ST_CHECK;
                end
            end
            ttb_pkg::ST_CHECK: begin
                n_state = (r_res[0] == '0) ? ttb_pkg::ST_FINISH : ttb_pkg::ST_LOAD;
            end
            ttb_pkg::ST_LOAD: begin
                n_state = ld_zero ? ttb_pkg::ST_FINISH : ttb_pkg::ST_SHIFT;
            end
            ttb_pkg::ST_SHIFT: begin
                if (!norm_hi && m_or[ttb_pkg::NORM_W-1]) begin
                    n_state = ttb_pkg::ST_SQUARE;
                end
            end
            ttb_pkg::ST_SQUARE: begin
                if (r_cnt == 4'd3) begin
                    root_start = 1'b1;
                    n_state    = ttb_pkg::ST_ROOT;
                end
            end
            ttb_pkg::ST_ROOT: begin
                if (root_done) begin
                    div_start = 1'b1;
                    n_state   = ttb_pkg::ST_DIV;
                end
            end
            ttb_pkg::ST_DIV: begin
                if (div_done) begin
                    if (r_comp != 2'd2) begin
                        div_start = 1'b1;
                    end else if (!r_vec) begin
                        n_state = ttb_pkg::ST_LOAD;
                    end else begin
                        n_state = ttb_pkg::ST_FINISH;
                    end
                end
            end
            ttb_pkg::ST_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = ttb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ttb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttb_pkg::ST_IDLE;
            r_phase     <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ttb_pkg::ST_IDLE: begin
                r_cnt   <= 4'd0;
                r_degen <= 1'b0;
                r_vec   <= 1'b0;
            end
            ttb_pkg::ST_PROD: begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt != 4'd0) begin
                    if (!prod_idx[0]) begin
                        r_acc <= prod_ext;
                    end else begin
                        r_res[prod_idx[3:1]] <= r_acc - prod_ext;
                    end
                end
            end
            ttb_pkg::ST_CHECK: begin
                if (r_res[0] == '0) begin
                    r_degen <= 1'b1;
                end
            end
            ttb_pkg::ST_LOAD: begin
                for (int k = 0; k < 3; k++) begin
                    r_m[k]   <= ld_mag[k];
                    r_neg[k] <= ld_src[k][ttb_pkg::ACC_W-1] ^ r_res[0][ttb_pkg::ACC_W-1];
                end
                if (ld_zero) begin
                    r_degen <= 1'b1;
                end
            end
            ttb_pkg::ST_SHIFT: begin
                r_cnt <= 4'd0;
                for (int k = 0; k < 3; k++) begin
                    if (norm_hi) begin
                        r_m[k] <= r_m[k] >> 1;
                    end else if (!m_or[ttb_pkg::NORM_W-1]) begin
                        r_m[k] <= r_m[k] << 1;
                    end
                end
            end
            ttb_pkg::ST_SQUARE: begin
                r_cnt <= r_cnt + 4'd1;
                r_sum <= (r_cnt == 4'd0) ? '0 : sq_total;
            end
            ttb_pkg::ST_ROOT: begin
                r_comp <= 2'd0;
                if (root_done) begin
                    r_len <= root_val;
                end
            end
            ttb_pkg::ST_DIV: begin
                if (div_done) begin
                    if (r_vec) begin
                        r_bq[r_comp] <= q_signed;
                    end else begin
                        r_tq[r_comp] <= q_signed;
                    end
                    r_comp <= r_comp + 2'd1;
                    if (r_comp == 2'd2) begin
                        r_vec <= 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.degenerate  <= r_degen;
            r_out.tangent_x   <= r_degen ? '0 : r_tq[0];
            r_out.tangent_y   <= r_degen ? '0 : r_tq[1];
            r_out.tangent_z   <= r_degen ? '0 : r_tq[2];
            r_out.bitangent_x <= r_degen ? '0 : r_bq[0];
            r_out.bitangent_y <= r_degen ? '0 : r_bq[1];
            r_out.bitangent_z <= r_degen ? '0 : r_bq[2];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    // The phase counter never reaches its unused code.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("triangle phase reached unused code");

    // A vertex that closes a triangle starts the product sequence.
    a_third_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && eff_phase == 2'd2) |=> (r_state == ttb_pkg::ST_PROD && r_cnt == 4'd0))
        else $error("third vertex did not start the product sequence");

    // The root and divider loops never finish in the same cycle.
    a_unit_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(root_done && div_done))
        else $error("root and divider finished together");
`endif

endmodule
